### hw/rtl/dle_stuffed_frame_receiver_core_defines.svh
// Assertion macros used by the checker file.
`ifndef DLE_STUFFED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define DLE_STUFFED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during rst.
`define DSFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsfr check failed");

// Next-cycle implication, sampled on clk, idle during rst.
`define DSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsfr check failed");

`endif

### hw/rtl/dsfr_pkg.sv
package dsfr_pkg;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_DISCARD = 3'd3,
    KIND_TEXT    = 3'd4,
    KIND_LINE    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  localparam logic [7:0] START_RESET  = 8'd85;
  localparam logic [7:0] END_RESET    = 8'd4;
  localparam logic [7:0] ESCAPE_RESET = 8'd5;
  localparam logic [7:0] ASCII_CR     = 8'h0D;
  localparam logic [7:0] ASCII_LF     = 8'h0A;
  localparam logic [7:0] PRINT_MIN    = 8'd32;

endpackage

### hw/rtl/dsfr_if.sv
interface dsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfr_out_if;
  logic                valid;
  logic                ready;
  dsfr_pkg::kind_t     kind;
  logic [7:0]          data_byte;
  logic [7:0]          length;

  modport source (output valid, output kind, output data_byte, output length, input ready);
  modport sink (input valid, input kind, input data_byte, input length, output ready);
endinterface

### hw/rtl/dsfr_in_reg.sv
module dsfr_in_reg (
  input  logic            clk,
  input  logic            rst,
  dsfr_in_if.sink         in_ch,
  output dsfr_pkg::stage_t stage,
  input  logic            stage_ready
);
  import dsfr_pkg::*;

  logic take;

  assign in_ch.ready = !stage.valid || stage_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // hold the beat until the engine takes it
  always_ff @(posedge clk) begin
    if (take) begin
      stage.rx_byte <= in_ch.rx_byte;
    end
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (take) begin
      stage.valid <= 1'b1;
    end else if (stage_ready) begin
      stage.valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/dsfr_engine.sv
module dsfr_engine #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  dsfr_pkg::cfg_t   cfg,
  input  dsfr_pkg::stage_t stage,
  output logic             stage_ready,
  dsfr_out_if.source       out_ch
);
  import dsfr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_START2 = 2'd1,
    PH_FRAME  = 2'd2
  } phase_t;

  localparam logic [7:0] FrameLimit = 8'(BUFFER_BYTES);
  localparam logic [7:0] TextLimit  = 8'(BUFFER_BYTES - 1);

  phase_t     phase, phase_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_byte, held_byte_next;
  logic       emit;
  kind_t      res_kind;
  logic [7:0] res_data;
  logic [7:0] res_len;
  logic [7:0] c;
  logic       advance;

  assign c           = stage.rx_byte;
  assign stage_ready = !out_ch.valid || out_ch.ready;
  assign advance     = stage.valid && stage_ready;

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    held_byte_next      = held_byte;
    emit                = 1'b0;
    res_kind            = KIND_PAYLOAD;
    res_data            = 8'd0;
    res_len             = 8'd0;
    unique case (phase)
      PH_START2: begin
        phase_next          = (c == cfg.start_code) ? PH_FRAME : PH_IDLE;
        escape_pending_next = 1'b0;
        byte_count_next     = 8'd0;
        running_sum_next    = 8'd0;
      end
      PH_FRAME: begin
        if (!escape_pending && c == cfg.start_code) begin
          escape_pending_next = 1'b0;
          byte_count_next     = 8'd0;
          running_sum_next    = 8'd0;
          emit                = 1'b1;
          res_kind            = KIND_DISCARD;
        end else if (!escape_pending && c == cfg.end_code) begin
          phase_next          = PH_IDLE;
          escape_pending_next = 1'b0;
          byte_count_next     = 8'd0;
          running_sum_next    = 8'd0;
          emit                = 1'b1;
          if (byte_count == 8'd0) begin
            res_kind = KIND_DISCARD;
          end else begin
            res_kind = (running_sum == 8'd0) ? KIND_GOOD : KIND_BAD;
            res_len  = byte_count - 8'd1;
          end
        end else if (!escape_pending && c == cfg.escape_code) begin
          escape_pending_next = 1'b1;
        end else begin
          escape_pending_next = 1'b0;
          if (byte_count < FrameLimit) begin
            // pass on the previous byte; the last one is the checksum
            if (byte_count != 8'd0) begin
              emit     = 1'b1;
              res_kind = KIND_PAYLOAD;
              res_data = held_byte;
            end
            held_byte_next   = c;
            byte_count_next  = byte_count + 8'd1;
            running_sum_next = running_sum + c;
          end else begin
            phase_next          = PH_IDLE;
            byte_count_next     = 8'd0;
            running_sum_next    = 8'd0;
            emit                = 1'b1;
            res_kind            = KIND_DISCARD;
          end
        end
      end
      default: begin
        if (c == cfg.start_code) begin
          phase_next          = PH_START2;
          escape_pending_next = 1'b0;
          byte_count_next     = 8'd0;
          running_sum_next    = 8'd0;
        end else begin
          phase_next = PH_IDLE;
          if (c >= PRINT_MIN) begin
            if (byte_count < TextLimit) begin
              byte_count_next = byte_count + 8'd1;
              emit            = 1'b1;
              res_kind        = KIND_TEXT;
              res_data        = c;
            end
          end else if (c == ASCII_CR || c == ASCII_LF) begin
            byte_count_next = 8'd0;
            if (byte_count != 8'd0) begin
              emit     = 1'b1;
              res_kind = KIND_LINE;
              res_len  = byte_count;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      escape_pending <= 1'b0;
      byte_count     <= 8'd0;
      running_sum    <= 8'd0;
      held_byte      <= 8'd0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (advance) begin
        phase          <= phase_next;
        escape_pending <= escape_pending_next;
        byte_count     <= byte_count_next;
        running_sum    <= running_sum_next;
        held_byte      <= held_byte_next;
        out_ch.valid   <= emit;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_ch.kind      <= res_kind;
      out_ch.data_byte <= res_data;
      out_ch.length    <= res_len;
    end
  end

endmodule

### hw/rtl/dle_stuffed_frame_receiver_core.sv
// Channel   Role    Payload
// in_ch     sink    rx_byte
// out_ch    source  kind, data_byte, length
// cfg_*     write   cfg_index, cfg_data
//
// One byte per cycle unless out_ch stalls; a result passes input reg, then result reg.
// The input register and the result register each hold one beat.
// A stalled result holds the engine; the input register takes one more beat meanwhile.
// Synchronous reset clears the frame state and loads the default codes.
module dle_stuffed_frame_receiver_core #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  dsfr_in_if.sink    in_ch,
  dsfr_out_if.source out_ch
);
  import dsfr_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code  <= START_RESET;
      cfg.end_code    <= END_RESET;
      cfg.escape_code <= ESCAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:  cfg.start_code  <= cfg_data;
        REG_END:    cfg.end_code    <= cfg_data;
        REG_ESCAPE: cfg.escape_code <= cfg_data;
        default: ;
      endcase
    end
  end

  dsfr_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  dsfr_engine #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage       (stage),
    .stage_ready (stage_ready),
    .out_ch      (out_ch)
  );

endmodule

### hw/rtl/dsfr_checker.sv
`include "dle_stuffed_frame_receiver_core_defines.svh"

module dsfr_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input dsfr_pkg::kind_t kind,
  input logic [7:0]      data_byte,
  input logic [7:0]      length
);
  import dsfr_pkg::*;

  `DSFR_ASSERT_NOW(a_data_zero, out_valid && kind != KIND_PAYLOAD && kind != KIND_TEXT, data_byte == 8'd0)
  `DSFR_ASSERT_NOW(a_len_zero, out_valid && (kind == KIND_PAYLOAD || kind == KIND_DISCARD || kind == KIND_TEXT), length == 8'd0)
  `DSFR_ASSERT_NOW(a_text_print, out_valid && kind == KIND_TEXT, data_byte >= PRINT_MIN)
  `DSFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_byte) && $stable(length))

endmodule

bind dle_stuffed_frame_receiver_core dsfr_checker u_dsfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .data_byte (out_ch.data_byte),
  .length    (out_ch.length)
);

### tb/tb.sv
module tb;
  import dsfr_pkg::*;

  localparam int BUF_BYTES    = 128;
  localparam int PHASE_BYTES  = 160;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 8;
  localparam int STALL_LIMIT  = 2000;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_START2 = 2'd1,
    ST_FRAME  = 2'd2
  } rx_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] length;
  } rx_result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       has;
    rx_result_t res;
  } dir_row_t;

  localparam rx_result_t NO_RESULT = '{KIND_PAYLOAD, 8'h00, 8'h00};

  localparam dir_row_t DIRECTED [26] = '{
    '{8'h41, 1'b1, 1'b1, '{KIND_TEXT, 8'h41, 8'h00}},
    '{8'hFF, 1'b1, 1'b1, '{KIND_TEXT, 8'hFF, 8'h00}},
    '{8'h20, 1'b1, 1'b1, '{KIND_TEXT, 8'h20, 8'h00}},
    '{8'h1F, 1'b1, 1'b0, NO_RESULT},
    '{8'h0D, 1'b1, 1'b1, '{KIND_LINE, 8'h00, 8'd3}},
    '{8'h0A, 1'b1, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, 1'b0, NO_RESULT},
    '{8'h04, 1'b0, 1'b0, NO_RESULT},
    '{8'h97, 1'b0, 1'b0, NO_RESULT},
    '{8'h04, 1'b1, 1'b1, '{KIND_GOOD, 8'h00, 8'd3}},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h04, 1'b1, 1'b1, '{KIND_DISCARD, 8'h00, 8'd0}},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h07, 1'b0, 1'b0, NO_RESULT},
    '{8'h55, 1'b1, 1'b1, '{KIND_DISCARD, 8'h00, 8'd0}},
    '{8'h01, 1'b0, 1'b0, NO_RESULT},
    '{8'h04, 1'b1, 1'b1, '{KIND_BAD, 8'h00, 8'd0}}
  };

  localparam cfg_t CODE_PLAN [8] = '{
    '{8'h55, 8'h04, 8'h05},
    '{8'h00, 8'hFF, 8'h0D},
    '{8'hFF, 8'h00, 8'h20},
    '{8'h7E, 8'h7E, 8'h7D},
    '{8'h10, 8'h0A, 8'h0A},
    '{8'h41, 8'h41, 8'h41},
    '{8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h04, 8'h05}
  };

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  dsfr_in_if  in_if ();
  dsfr_out_if out_if ();

  dle_stuffed_frame_receiver_core #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  cfg_t       codes      = '{START_RESET, END_RESET, ESCAPE_RESET};
  rx_phase_t  fr_phase   = ST_IDLE;
  bit         esc_armed  = 1'b0;
  logic [7:0] held_count = 8'd0;
  logic [7:0] check_sum  = 8'd0;
  logic [7:0] last_byte  = 8'd0;

  rx_result_t rx_results_q [$];

  logic       pin_on  = 1'b0;
  logic       pin_has = 1'b0;
  rx_result_t pin_res = NO_RESULT;

  bit no_gaps  = 1'b0;
  bit hold_req = 1'b0;

  int mismatches     = 0;
  int bytes_sent     = 0;
  int results_seen   = 0;
  int frames_closed  = 0;
  int discards_seen  = 0;
  int stall_cycles   = 0;

  function automatic void restart_count();
    held_count = 8'd0;
    check_sum  = 8'd0;
    esc_armed  = 1'b0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] c, output rx_result_t r);
    bit         hit;
    logic [7:0] n;
    hit = 1'b0;
    r   = NO_RESULT;
    case (fr_phase)
      ST_START2: begin
        fr_phase = (c == codes.start_code) ? ST_FRAME : ST_IDLE;
        restart_count();
      end
      ST_FRAME: begin
        if (!esc_armed && c == codes.start_code) begin
          restart_count();
          r.kind = KIND_DISCARD;
          hit = 1'b1;
        end else if (!esc_armed && c == codes.end_code) begin
          n = held_count;
          r.kind = (check_sum == 8'd0) ? KIND_GOOD : KIND_BAD;
          fr_phase = ST_IDLE;
          restart_count();
          if (n == 8'd0) r.kind = KIND_DISCARD;
          else r.length = n - 8'd1;
          hit = 1'b1;
        end else if (!esc_armed && c == codes.escape_code) begin
          esc_armed = 1'b1;
        end else begin
          esc_armed = 1'b0;
          if (held_count < BUF_BYTES) begin
            if (held_count != 8'd0) begin
              r.data_byte = last_byte;
              hit = 1'b1;
            end
            last_byte  = c;
            held_count = held_count + 8'd1;
            check_sum  = check_sum + c;
          end else begin
            fr_phase = ST_IDLE;
            restart_count();
            r.kind = KIND_DISCARD;
            hit = 1'b1;
          end
        end
      end
      default: begin
        if (c == codes.start_code) begin
          fr_phase = ST_START2;
          restart_count();
        end else begin
          fr_phase = ST_IDLE;
          if (c >= PRINT_MIN) begin
            if (held_count < BUF_BYTES - 1) begin
              held_count = held_count + 8'd1;
              r.kind = KIND_TEXT;
              r.data_byte = c;
              hit = 1'b1;
            end
          end else if (c == ASCII_CR || c == ASCII_LF) begin
            if (held_count != 8'd0) begin
              r.kind = KIND_LINE;
              r.length = held_count;
              hit = 1'b1;
            end
            held_count = 8'd0;
          end
        end
      end
    endcase
    return hit;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rx_result_t res;
    bit         hit;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START:  codes.start_code  = cfg_data;
          REG_END:    codes.end_code    = cfg_data;
          REG_ESCAPE: codes.escape_code = cfg_data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        hit = deframe_byte(in_if.rx_byte, res);
        if (pin_on) begin
          hit = pin_has;
          res = pin_res;
        end
        if (hit) rx_results_q.push_back(res);
      end
    end
  end

  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (rx_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: expected none, got kind %0d data %02h length %0d",
                 $time, out_if.kind, out_if.data_byte, out_if.length);
      end else begin
        want = rx_results_q.pop_front();
        results_seen++;
        if (want.kind inside {KIND_GOOD, KIND_BAD}) frames_closed++;
        if (want.kind == KIND_DISCARD) discards_seen++;
        if (out_if.kind !== want.kind || out_if.data_byte !== want.data_byte ||
            out_if.length !== want.length) begin
          mismatches++;
          $display("%0t: expected kind %0d data %02h length %0d, got kind %0d data %02h length %0d",
                   $time, want.kind, want.data_byte, want.length,
                   out_if.kind, out_if.data_byte, out_if.length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic typed = 1'b0,
                           input logic has = 1'b0, input rx_result_t res = NO_RESULT);
    if (!no_gaps) begin
      while ($urandom_range(99) < 24) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    pin_on        <= typed;
    pin_has       <= has;
    pin_res       <= res;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == codes.start_code || b == codes.end_code || b == codes.escape_code)
      send_beat(codes.escape_code);
    send_beat(b);
  endtask

  task automatic send_frame();
    int         n;
    int         flaw;
    logic [7:0] sum;
    logic [7:0] b;
    n    = ($urandom_range(39) == 0) ? $urandom_range(120, 130) : $urandom_range(0, 10);
    flaw = $urandom_range(9);
    sum  = 8'd0;
    send_beat(codes.start_code);
    send_beat(codes.start_code);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (flaw == 1 && i == n / 2) send_beat(codes.start_code);
      send_stuffed(b);
      sum = sum + b;
    end
    if (n > 0 || $urandom_range(1) == 1)
      send_stuffed((flaw == 2) ? sum : 8'(8'd0 - sum));
    if (flaw != 0) send_beat(codes.end_code);
  endtask

  task automatic send_text_line();
    int         n;
    logic [7:0] b;
    n = ($urandom_range(39) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(32, 255));
      if (b == codes.start_code) b = b ^ 8'h01;
      send_beat(b);
    end
    case ($urandom_range(4))
      0: ;
      1, 2: send_beat(ASCII_CR);
      default: send_beat(ASCII_LF);
    endcase
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: send_beat(codes.start_code);
        1: send_beat(codes.end_code);
        2: send_beat(codes.escape_code);
        3: send_beat(ASCII_CR);
        4: send_beat(ASCII_LF);
        default: send_beat(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (rx_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic load_codes(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START;
    cfg_data  <= c.start_code;
    @(posedge clk);
    cfg_index <= REG_END;
    cfg_data  <= c.end_code;
    @(posedge clk);
    cfg_index <= REG_ESCAPE;
    cfg_data  <= c.escape_code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int   target;
    int   pick;
    cfg_t c;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_START;
    cfg_data      = 8'd0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].has, DIRECTED[i].res);

    for (int p = 0; p < 8; p++) begin
      settle();
      if (p > 0) begin
        c = CODE_PLAN[p];
        if (p == 6) c = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255))};
        load_codes(c);
      end
      no_gaps = (p == 3);
      // stall the result side while bytes keep being offered
      if (p == 2) hold_req = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 60) send_frame();
        else if (pick < 80) send_text_line();
        else send_noise();
      end
    end
    no_gaps = 1'b0;
    settle();

    $display("Sent %0d bytes, checked %0d results (%0d frame ends, %0d discards)",
             bytes_sent, results_seen, frames_closed, discards_seen);
    $display("Covered 8 code settings incl. equal and extreme codes, a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
